// ===== src/fbtr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbtr_pkg
// Shared types and constants of the framebuffer text recognizer.
// ----------------------------------------------------------------------------
package fbtr_pkg;

  localparam int unsigned GLYPH_ENTRIES_DEF = 259;
  localparam int unsigned PAT_W   = 64;
  localparam int unsigned CODE_W  = 8;
  localparam int unsigned GLYPH_W = PAT_W + CODE_W + 1;  // {valid, code, pattern}
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned CNT_W = 8;

  localparam logic [PAT_W-1:0]  AMBIG_PATTERN = 64'h66003c6666663c00;
  localparam logic [CODE_W-1:0] CHAR_ALT      = 8'h95;
  localparam logic [CODE_W-1:0] CHAR_STD      = 8'h85;
  localparam logic [CODE_W-1:0] CHAR_SPACE    = 8'h20;
  localparam logic [CODE_W-1:0] CHAR_NUL      = 8'h00;

  localparam logic [7:0] MASK_2BPP_0 = 8'h88;
  localparam logic [7:0] MASK_2BPP_1 = 8'h44;
  localparam logic [7:0] MASK_2BPP_2 = 8'h22;
  localparam logic [7:0] MASK_2BPP_3 = 8'h11;
  localparam logic [7:0] MASK_4BPP_0 = 8'haa;
  localparam logic [7:0] MASK_4BPP_1 = 8'h55;

  localparam logic [1:0] CFG_BG_MASK = 2'd0;
  localparam logic [1:0] CFG_PIX_FMT = 2'd1;
  localparam logic [1:0] CFG_ALT_ROM = 2'd2;

  localparam logic [1:0] FMT_1BPP = 2'd0;
  localparam logic [1:0] FMT_2BPP = 2'd1;
  localparam logic [1:0] FMT_4BPP = 2'd2;
  localparam logic [1:0] FMT_RSVD = 2'd3;  // folds as four bits per pixel

  typedef enum logic [1:0] {
    CMD_LOAD = 2'd0,
    CMD_LINE = 2'd1,
    CMD_TTX  = 2'd2,
    CMD_EOS  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_INIT,
    ST_IDLE,
    ST_SEARCH,
    ST_FIN
  } back_st_t;

  typedef struct packed {
    logic [7:0] bg_mask;
    logic [1:0] pix_fmt;
    logic       alt_rom;
  } cfg_t;

  // Request handed from front to back. For a finished cell kind is CMD_LINE.
  typedef struct packed {
    cmd_t              kind;
    logic [8:0]        idx;
    logic [PAT_W-1:0]  pat;
    logic [CODE_W-1:0] code;
    logic              row_end;
  } op_t;

endpackage

// ===== src/fbtr_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbtr_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
module fbtr_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== src/fbtr_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbtr_queue
// Short request queue between front and back.
// ----------------------------------------------------------------------------
module fbtr_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push_valid,
  output logic           push_ready,
  input  fbtr_pkg::op_t  push_data,
  output logic           pop_valid,
  input  logic           pop_ready,
  output fbtr_pkg::op_t  pop_data
);

  localparam int unsigned QD  = fbtr_pkg::QUEUE_DEPTH;
  localparam int unsigned PW  = (QD > 1) ? $clog2(QD) : 1;
  localparam int unsigned CW  = $clog2(QD + 1);

  fbtr_pkg::op_t mem_r [QD];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          do_push, do_pop;

  assign push_ready = (cnt_r != CW'(QD));
  assign pop_valid  = (cnt_r != '0);
  assign pop_data   = mem_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(QD - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(QD - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ===== src/fbtr_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbtr_front
// Input side: folds raster lines into cells and queues requests.
// ----------------------------------------------------------------------------
module fbtr_front (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  fbtr_pkg::cmd_t              cmd,
  input  logic [8:0]                  entry_index,
  input  logic [fbtr_pkg::PAT_W-1:0]  glyph_pattern,
  input  logic [fbtr_pkg::CODE_W-1:0] glyph_code,
  input  logic [7:0]                  byte0,
  input  logic [7:0]                  byte1,
  input  logic [7:0]                  byte2,
  input  logic [7:0]                  byte3,
  input  logic                        row_end,
  input  logic                        run,
  input  fbtr_pkg::cfg_t              cfg,
  output logic                        q_valid,
  input  logic                        q_ready,
  output fbtr_pkg::op_t               q_data
);

  logic [fbtr_pkg::PAT_W-1:0] cell_r, cell_nxt;
  logic [2:0]                 lcnt_r, lcnt_nxt;
  logic [7:0]                 b0, b1, b2, b3, fold;
  logic                       accept;

  assign in_ready = run && q_ready;
  assign accept   = in_valid && in_ready;
  assign b0 = byte0 ^ cfg.bg_mask;
  assign b1 = byte1 ^ cfg.bg_mask;
  assign b2 = byte2 ^ cfg.bg_mask;
  assign b3 = byte3 ^ cfg.bg_mask;

  always_comb begin
    case (cfg.pix_fmt)
      fbtr_pkg::FMT_1BPP: fold = b0;
      fbtr_pkg::FMT_2BPP: fold = {|(b0 & fbtr_pkg::MASK_2BPP_0), |(b0 & fbtr_pkg::MASK_2BPP_1),
                                  |(b0 & fbtr_pkg::MASK_2BPP_2), |(b0 & fbtr_pkg::MASK_2BPP_3),
                                  |(b1 & fbtr_pkg::MASK_2BPP_0), |(b1 & fbtr_pkg::MASK_2BPP_1),
                                  |(b1 & fbtr_pkg::MASK_2BPP_2), |(b1 & fbtr_pkg::MASK_2BPP_3)};
      default:            fold = {|(b0 & fbtr_pkg::MASK_4BPP_0), |(b0 & fbtr_pkg::MASK_4BPP_1),
                                  |(b1 & fbtr_pkg::MASK_4BPP_0), |(b1 & fbtr_pkg::MASK_4BPP_1),
                                  |(b2 & fbtr_pkg::MASK_4BPP_0), |(b2 & fbtr_pkg::MASK_4BPP_1),
                                  |(b3 & fbtr_pkg::MASK_4BPP_0), |(b3 & fbtr_pkg::MASK_4BPP_1)};
    endcase
  end

  always_comb begin
    cell_nxt        = cell_r;
    lcnt_nxt        = lcnt_r;
    q_valid         = 1'b0;
    q_data.kind     = cmd;
    q_data.idx      = entry_index;
    q_data.pat      = glyph_pattern;
    q_data.code     = glyph_code;
    q_data.row_end  = row_end;
    if (accept) begin
      unique case (cmd)
        fbtr_pkg::CMD_LOAD: begin
          q_valid = 1'b1;
        end
        fbtr_pkg::CMD_LINE: begin
          q_data.pat = {cell_r[fbtr_pkg::PAT_W-9:0], fold};
          if (lcnt_r != 3'd7) begin
            cell_nxt = q_data.pat;
            lcnt_nxt = lcnt_r + 3'd1;
          end else begin
            q_valid  = 1'b1;
            cell_nxt = '0;
            lcnt_nxt = '0;
          end
        end
        fbtr_pkg::CMD_TTX: begin
          q_data.code = byte0;
          q_valid     = 1'b1;
        end
        fbtr_pkg::CMD_EOS: begin
          q_valid  = 1'b1;
          cell_nxt = '0;
          lcnt_nxt = '0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cell_r <= '0;
      lcnt_r <= '0;
    end else begin
      cell_r <= cell_nxt;
      lcnt_r <= lcnt_nxt;
    end
  end

endmodule

// ===== src/fbtr_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbtr_back
// Glyph table, sequential first-match search and text trimming.
// ----------------------------------------------------------------------------
module fbtr_back #(
  parameter int unsigned GLYPH_ENTRIES = fbtr_pkg::GLYPH_ENTRIES_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        q_valid,
  output logic                        q_ready,
  input  fbtr_pkg::op_t               q_data,
  input  fbtr_pkg::cfg_t              cfg,
  output logic                        run,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [fbtr_pkg::CNT_W-1:0]  out_nl,
  output logic [fbtr_pkg::CNT_W-1:0]  out_sp,
  output logic [fbtr_pkg::CODE_W-1:0] out_ch,
  output logic                        out_fin
);

  localparam int unsigned AW = (GLYPH_ENTRIES > 1) ? $clog2(GLYPH_ENTRIES) : 1;
  localparam logic [AW-1:0] LAST = AW'(GLYPH_ENTRIES - 1);
  localparam int unsigned CW = fbtr_pkg::CNT_W;

  fbtr_pkg::back_st_t st_r, st_nxt;
  logic [AW-1:0] clr_r, clr_nxt;
  logic [AW-1:0] scan_r, scan_nxt;
  logic          chk_r, chk_nxt;
  logic          last_r, last_nxt;
  logic [fbtr_pkg::PAT_W-1:0]  pat_r, pat_nxt;
  logic [fbtr_pkg::CODE_W-1:0] ch_r, ch_nxt;
  logic          row_end_r, row_end_nxt;
  fbtr_pkg::cmd_t kind_r, kind_nxt;
  logic [CW-1:0] nl_r, nl_nxt, sp_r, sp_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [CW-1:0] out_nl_r, out_nl_nxt, out_sp_r, out_sp_nxt;
  logic [fbtr_pkg::CODE_W-1:0] out_ch_r, out_ch_nxt;
  logic          out_fin_r, out_fin_nxt;

  logic                          we;
  logic [AW-1:0]                 waddr;
  logic [fbtr_pkg::GLYPH_W-1:0]  wdata, rdata;
  logic                          r_vld;
  logic [fbtr_pkg::CODE_W-1:0]   r_code, m_code, m_ch;
  logic [fbtr_pkg::PAT_W-1:0]    r_pat;
  logic                          hit, out_free, blank, emit, is_eos;

  fbtr_ram #(
    .WIDTH (fbtr_pkg::GLYPH_W),
    .DEPTH (GLYPH_ENTRIES)
  ) u_table (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (scan_r),
    .rdata (rdata)
  );

  assign r_vld  = rdata[fbtr_pkg::GLYPH_W-1];
  assign r_code = rdata[fbtr_pkg::PAT_W +: fbtr_pkg::CODE_W];
  assign r_pat  = rdata[fbtr_pkg::PAT_W-1:0];
  assign hit    = chk_r && r_vld && (r_pat == pat_r);
  assign m_code = hit ? r_code : fbtr_pkg::CHAR_NUL;
  assign m_ch   = (m_code != fbtr_pkg::CHAR_NUL) ? m_code :
                  (pat_r == fbtr_pkg::AMBIG_PATTERN) ?
                  (cfg.alt_rom ? fbtr_pkg::CHAR_ALT : fbtr_pkg::CHAR_STD) :
                  fbtr_pkg::CHAR_SPACE;

  assign out_free = !out_valid_r || out_ready;
  assign is_eos   = (kind_r == fbtr_pkg::CMD_EOS);
  assign blank    = (ch_r == fbtr_pkg::CHAR_SPACE) || (ch_r == fbtr_pkg::CHAR_NUL);
  assign emit     = is_eos ? (nl_r != '0) : !blank;

  assign run       = (st_r != fbtr_pkg::ST_INIT);
  assign out_valid = out_valid_r;
  assign out_nl    = out_nl_r;
  assign out_sp    = out_sp_r;
  assign out_ch    = out_ch_r;
  assign out_fin   = out_fin_r;

  always_comb begin
    logic [CW-1:0] nl_t, sp_t;
    nl_t          = nl_r;
    sp_t          = sp_r;
    st_nxt        = st_r;
    clr_nxt       = clr_r;
    scan_nxt      = scan_r;
    chk_nxt       = chk_r;
    last_nxt      = last_r;
    pat_nxt       = pat_r;
    ch_nxt        = ch_r;
    row_end_nxt   = row_end_r;
    kind_nxt      = kind_r;
    nl_nxt        = nl_r;
    sp_nxt        = sp_r;
    out_valid_nxt = out_ready ? 1'b0 : out_valid_r;
    out_nl_nxt    = out_nl_r;
    out_sp_nxt    = out_sp_r;
    out_ch_nxt    = out_ch_r;
    out_fin_nxt   = out_fin_r;
    q_ready       = 1'b0;
    we            = 1'b0;
    waddr         = q_data.idx[AW-1:0];
    wdata         = {1'b1, q_data.code, q_data.pat};

    unique case (st_r)
      fbtr_pkg::ST_INIT: begin
        we    = 1'b1;
        waddr = clr_r;
        wdata = '0;
        if (clr_r == LAST) begin
          st_nxt = fbtr_pkg::ST_IDLE;
        end else begin
          clr_nxt = clr_r + AW'(1);
        end
      end
      fbtr_pkg::ST_IDLE: begin
        if (q_valid) begin
          q_ready     = 1'b1;
          kind_nxt    = q_data.kind;
          pat_nxt     = q_data.pat;
          ch_nxt      = q_data.code;
          row_end_nxt = q_data.row_end;
          unique case (q_data.kind)
            fbtr_pkg::CMD_LOAD: begin
              we = ({1'b0, q_data.idx} < 10'(GLYPH_ENTRIES));
            end
            fbtr_pkg::CMD_LINE: begin
              scan_nxt = '0;
              chk_nxt  = 1'b0;
              last_nxt = 1'b0;
              st_nxt   = fbtr_pkg::ST_SEARCH;
            end
            default: begin
              st_nxt = fbtr_pkg::ST_FIN;
            end
          endcase
        end
      end
      fbtr_pkg::ST_SEARCH: begin
        if (chk_r && (hit || last_r)) begin
          ch_nxt = m_ch;
          st_nxt = fbtr_pkg::ST_FIN;
        end else begin
          chk_nxt  = 1'b1;
          last_nxt = (scan_r == LAST);
          scan_nxt = (scan_r == LAST) ? scan_r : scan_r + AW'(1);
        end
      end
      fbtr_pkg::ST_FIN: begin
        if (!emit || out_free) begin
          st_nxt = fbtr_pkg::ST_IDLE;
          if (emit) begin
            out_valid_nxt = 1'b1;
            out_nl_nxt    = is_eos ? '0 : nl_r;
            out_sp_nxt    = is_eos ? '0 : sp_r;
            out_ch_nxt    = is_eos ? fbtr_pkg::CHAR_NUL : ch_r;
            out_fin_nxt   = is_eos;
          end
          if (is_eos) begin
            nl_t = '0;
            sp_t = '0;
          end else begin
            if (blank) begin
              sp_t = (sp_r == '1) ? sp_r : sp_r + CW'(1);
            end else begin
              nl_t = '0;
              sp_t = '0;
            end
            if (row_end_r) begin
              nl_t = (nl_t == '1) ? nl_t : nl_t + CW'(1);
              sp_t = '0;
            end
          end
          nl_nxt = nl_t;
          sp_nxt = sp_t;
        end
      end
      default: st_nxt = fbtr_pkg::ST_INIT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= fbtr_pkg::ST_INIT;
      clr_r       <= '0;
      chk_r       <= 1'b0;
      last_r      <= 1'b0;
      nl_r        <= '0;
      sp_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      clr_r       <= clr_nxt;
      chk_r       <= chk_nxt;
      last_r      <= last_nxt;
      nl_r        <= nl_nxt;
      sp_r        <= sp_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    scan_r    <= scan_nxt;
    pat_r     <= pat_nxt;
    ch_r      <= ch_nxt;
    row_end_r <= row_end_nxt;
    kind_r    <= kind_nxt;
    out_nl_r  <= out_nl_nxt;
    out_sp_r  <= out_sp_nxt;
    out_ch_r  <= out_ch_nxt;
    out_fin_r <= out_fin_nxt;
  end

endmodule

// ===== src/framebuffer_text_recognizer_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// framebuffer_text_recognizer_core
// Screen cells to trimmed text: line folding, glyph search, blank deferral.
// ----------------------------------------------------------------------------
// Line, load, teletext and end-of-screen requests are taken one per cycle while the queue has room.
// A finished cell searches the glyph table one entry per cycle on the RAM read port,
// stopping at the first valid match or after the last entry.
// Teletext and end-of-screen requests pass from ST_IDLE through ST_FIN; loads are written from ST_IDLE.
// After reset a clearing pass zeroes the table with in_tready
// low; configuration writes are taken throughout.
module framebuffer_text_recognizer_core #(
  parameter int unsigned GLYPH_ENTRIES = fbtr_pkg::GLYPH_ENTRIES_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // entry_index, glyph_pattern, glyph_code, byte0, byte1, byte2, byte3, zero pad
  input  logic [119:0] in_tdata,
  // cmd
  input  logic [1:0]   in_tuser,
  input  logic         in_tlast,
  output logic         out_tvalid,
  input  logic         out_tready,
  // lead_newlines, lead_spaces, char_code
  output logic [23:0]  out_tdata,
  // final_newline
  output logic         out_tuser,
  input  logic         cfg_we,
  input  logic [1:0]   cfg_index,
  input  logic [7:0]   cfg_wdata
);

  fbtr_pkg::cfg_t cfg_r, cfg_nxt;
  fbtr_pkg::op_t  push_data, pop_data;
  logic           push_valid, push_ready, pop_valid, pop_ready, back_run;
  logic [7:0]     out_nl, out_sp, out_ch;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        fbtr_pkg::CFG_BG_MASK: cfg_nxt.bg_mask = cfg_wdata;
        fbtr_pkg::CFG_PIX_FMT: cfg_nxt.pix_fmt = cfg_wdata[1:0];
        fbtr_pkg::CFG_ALT_ROM: cfg_nxt.alt_rom = cfg_wdata[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  fbtr_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_tvalid),
    .in_ready      (in_tready),
    .cmd           (fbtr_pkg::cmd_t'(in_tuser)),
    .entry_index   (in_tdata[8:0]),
    .glyph_pattern (in_tdata[72:9]),
    .glyph_code    (in_tdata[80:73]),
    .byte0         (in_tdata[88:81]),
    .byte1         (in_tdata[96:89]),
    .byte2         (in_tdata[104:97]),
    .byte3         (in_tdata[112:105]),
    .row_end       (in_tlast),
    .run           (back_run),
    .cfg           (cfg_r),
    .q_valid       (push_valid),
    .q_ready       (push_ready),
    .q_data        (push_data)
  );

  fbtr_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  fbtr_back #(
    .GLYPH_ENTRIES (GLYPH_ENTRIES)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (pop_valid),
    .q_ready   (pop_ready),
    .q_data    (pop_data),
    .cfg       (cfg_r),
    .run       (back_run),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_nl    (out_nl),
    .out_sp    (out_sp),
    .out_ch    (out_ch),
    .out_fin   (out_tuser)
  );

  assign out_tdata = {out_ch, out_sp, out_nl};

  a_init_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    !back_run |-> !in_tready)
    else $error("input taken during table clearing");

  a_final_payload_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata == 24'd0)
    else $error("closing newline carries payload");

  a_char_nonblank: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |->
      out_tdata[23:16] != fbtr_pkg::CHAR_SPACE && out_tdata[23:16] != fbtr_pkg::CHAR_NUL)
    else $error("blank character emitted");

  a_push_has_room: assert property (@(posedge clk) disable iff (!rst_n)
    push_valid |-> push_ready)
    else $error("request pushed into full queue");

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for framebuffer_text_recognizer_core. After reset the
// whole glyph table is loaded and a short directed run hits the blank,
// ambiguous glyph, ignored slot and end-of-screen cases. Random phases follow,
// each under its own register setting: whole bitmap cells built to hit table
// entries, teletext, reloads, end-of-screen markers, broken cells and noise.
// One phase runs a saturation burst on the pending counts. Each accepted
// request goes through a local model of the block; every result is checked
// in order, field by field.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int NGLYPH = fbtr_pkg::GLYPH_ENTRIES_DEF;
  localparam int LIMIT = 1000000;
  localparam int SETTLE = 1000;

  typedef struct packed {
    fbtr_pkg::cmd_t cmd;
    logic [8:0]     idx;
    logic [63:0]    pat;
    logic [7:0]     code;
    logic [31:0]    by;
    logic           row_end;
  } screen_req_t;

  typedef struct packed {
    logic [7:0] nl;
    logic [7:0] sp;
    logic [7:0] ch;
    logic       fin;
  } text_out_t;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [119:0] in_tdata = '0;
  logic [1:0]   in_tuser = '0;
  logic         in_tlast = 1'b0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [23:0]  out_tdata;
  logic         out_tuser;
  logic         cfg_we = 1'b0;
  logic [1:0]   cfg_index = '0;
  logic [7:0]   cfg_wdata = '0;

  framebuffer_text_recognizer_core u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .in_tuser(in_tuser), .in_tlast(in_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // register copies, shared by generator and model (only change while idle)
  logic [7:0] cfg_bg = '0;
  logic [1:0] cfg_fmt = '0;
  logic       cfg_alt = 1'b0;

  // model state
  logic [63:0] t_pat [NGLYPH];
  logic [7:0]  t_code [NGLYPH];
  bit          t_vld [NGLYPH];
  logic [63:0] cell_acc = '0;
  int          lines_in = 0;
  logic [7:0]  nl_pend = '0;
  logic [7:0]  sp_pend = '0;

  // generator view of the table
  logic [63:0] gen_pat [NGLYPH];

  screen_req_t pend_reqs[$];
  text_out_t   text_q[$];
  screen_req_t cur_req;

  bit calm = 1'b0;
  int n_reqs = 0;
  int n_texts = 0;
  int n_bad = 0;
  int n_loads = 0, n_cells = 0, n_ttx = 0, n_eos = 0;
  int cycles = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;

  // ---------------- model ----------------
  function automatic logic [7:0] fold_line(logic [31:0] by);
    logic [31:0] x;
    logic [7:0] r;
    int i;
    x = by ^ {4{cfg_bg}};
    r = '0;
    if (cfg_fmt == fbtr_pkg::FMT_1BPP) begin
      r = x[7:0];
    end else if (cfg_fmt == fbtr_pkg::FMT_2BPP) begin
      for (i = 0; i < 2; i++)
        r = {r[3:0], |(x[8*i +: 8] & fbtr_pkg::MASK_2BPP_0),
             |(x[8*i +: 8] & fbtr_pkg::MASK_2BPP_1),
             |(x[8*i +: 8] & fbtr_pkg::MASK_2BPP_2),
             |(x[8*i +: 8] & fbtr_pkg::MASK_2BPP_3)};
    end else begin
      for (i = 0; i < 4; i++)
        r = {r[5:0], |(x[8*i +: 8] & fbtr_pkg::MASK_4BPP_0),
             |(x[8*i +: 8] & fbtr_pkg::MASK_4BPP_1)};
    end
    return r;
  endfunction

  function automatic logic [7:0] match_cell(logic [63:0] bits);
    logic [7:0] code;
    bit found;
    int i;
    code = fbtr_pkg::CHAR_NUL;
    found = 1'b0;
    for (i = 0; i < NGLYPH; i++) begin
      if (!found && t_vld[i] && t_pat[i] == bits) begin
        code = t_code[i];
        found = 1'b1;
      end
    end
    if (code == fbtr_pkg::CHAR_NUL)
      code = (bits == fbtr_pkg::AMBIG_PATTERN) ?
             (cfg_alt ? fbtr_pkg::CHAR_ALT : fbtr_pkg::CHAR_STD) : fbtr_pkg::CHAR_SPACE;
    return code;
  endfunction

  function automatic void place_char(bit blank, logic [7:0] ch, logic row_end);
    if (blank) begin
      if (sp_pend != 8'hff) sp_pend++;
    end else begin
      text_q.push_back('{nl_pend, sp_pend, ch, 1'b0});
      nl_pend = '0;
      sp_pend = '0;
    end
    if (row_end) begin
      if (nl_pend != 8'hff) nl_pend++;
      sp_pend = '0;
    end
  endfunction

  function automatic void scan_request(screen_req_t r);
    logic [7:0] ch;
    case (r.cmd)
      fbtr_pkg::CMD_LOAD: begin
        n_loads++;
        if (r.idx < NGLYPH) begin
          t_pat[r.idx] = r.pat;
          t_code[r.idx] = r.code;
          t_vld[r.idx] = 1'b1;
        end
      end
      fbtr_pkg::CMD_LINE: begin
        cell_acc = {cell_acc[55:0], fold_line(r.by)};
        if (lines_in < 7) begin
          lines_in++;
        end else begin
          ch = match_cell(cell_acc);
          cell_acc = '0;
          lines_in = 0;
          n_cells++;
          place_char(ch == fbtr_pkg::CHAR_SPACE, ch, r.row_end);
        end
      end
      fbtr_pkg::CMD_TTX: begin
        n_ttx++;
        ch = r.by[7:0];
        place_char(ch == fbtr_pkg::CHAR_NUL || ch == fbtr_pkg::CHAR_SPACE, ch, r.row_end);
      end
      default: begin
        n_eos++;
        if (nl_pend != 0) text_q.push_back('{8'd0, 8'd0, 8'd0, 1'b1});
        nl_pend = '0;
        sp_pend = '0;
        cell_acc = '0;
        lines_in = 0;
      end
    endcase
  endfunction

  // ---------------- driver ----------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_tready) begin
      if (in_tvalid) begin
        scan_request(cur_req);
        n_reqs <= n_reqs + 1;
      end
      if (pend_reqs.size() != 0 && (calm || $urandom_range(0, 99) >= 15)) begin
        cur_req = pend_reqs.pop_front();
        in_tdata <= {7'd0, cur_req.by, cur_req.code, cur_req.pat, cur_req.idx};
        in_tuser <= cur_req.cmd;
        in_tlast <= cur_req.row_end;
        in_tvalid <= 1'b1;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // ---------------- monitor ----------------
  always @(posedge clk) begin : mon
    text_out_t got, want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        got = '{out_tdata[7:0], out_tdata[15:8], out_tdata[23:16], out_tuser};
        if (text_q.size() == 0) begin
          if (n_bad < 10)
            $display("unexpected result nl=%0d sp=%0d ch=%h fin=%b",
                     got.nl, got.sp, got.ch, got.fin);
          n_bad++;
        end else begin
          want = text_q.pop_front();
          if (got.nl !== want.nl || got.sp !== want.sp || got.ch !== want.ch ||
              got.fin !== want.fin) begin
            if (n_bad < 10)
              $display({"mismatch #%0d: exp nl=%0d sp=%0d ch=%h fin=%b,",
                        " got nl=%0d sp=%0d ch=%h fin=%b"},
                       n_texts, want.nl, want.sp, want.ch, want.fin,
                       got.nl, got.sp, got.ch, got.fin);
            n_bad++;
          end
        end
        n_texts <= n_texts + 1;
      end
      out_tready <= (hold_left == 0) && (calm || $urandom_range(0, 99) >= 15);
    end
  end

  // long receiver hold-off, once, while requests keep coming
  always @(posedge clk) begin
    if (!hold_done && n_reqs >= 330) begin
      hold_left <= 3000;
      hold_done <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("status: fail");
      $finish;
    end
  end

  // ---------------- stimulus ----------------
  function automatic screen_req_t rand_req();
    screen_req_t r;
    r.cmd = fbtr_pkg::cmd_t'($urandom_range(0, 3));
    r.idx = 9'($urandom_range(0, 511));
    r.pat = {$urandom, $urandom};
    r.code = 8'($urandom_range(0, 255));
    r.by = $urandom;
    r.row_end = 1'($urandom_range(0, 1));
    return r;
  endfunction

  // random line bytes that fold to the wanted bits under the current setting
  function automatic logic [31:0] unfold_line(logic [7:0] bits);
    logic [31:0] x;
    logic [7:0] m;
    int i, k;
    x = $urandom;
    if (cfg_fmt == fbtr_pkg::FMT_1BPP) begin
      x[7:0] = bits;
    end else if (cfg_fmt == fbtr_pkg::FMT_2BPP) begin
      for (i = 0; i < 2; i++)
        for (k = 0; k < 4; k++) begin
          m = fbtr_pkg::MASK_2BPP_0 >> k;
          if (!bits[7 - (4*i + k)])
            x[8*i +: 8] = x[8*i +: 8] & ~m;
          else if ((x[8*i +: 8] & m) == 0)
            x[8*i +: 8] = x[8*i +: 8] | (m & ($urandom_range(0, 1) ? 8'hf0 : 8'h0f));
        end
    end else begin
      for (i = 0; i < 4; i++)
        for (k = 0; k < 2; k++) begin
          m = k ? fbtr_pkg::MASK_4BPP_1 : fbtr_pkg::MASK_4BPP_0;
          if (!bits[7 - (2*i + k)])
            x[8*i +: 8] = x[8*i +: 8] & ~m;
          else if ((x[8*i +: 8] & m) == 0)
            x[8*i +: 8] = x[8*i +: 8] | (m & (8'h03 << (2 * $urandom_range(0, 3))));
        end
    end
    return x ^ {4{cfg_bg}};
  endfunction

  task automatic push_load(logic [8:0] idx, logic [63:0] pat, logic [7:0] code);
    screen_req_t r;
    r = rand_req();
    r.cmd = fbtr_pkg::CMD_LOAD;
    r.idx = idx;
    r.pat = pat;
    r.code = code;
    if (idx < NGLYPH) gen_pat[idx] = pat;
    pend_reqs.push_back(r);
  endtask

  task automatic push_ttx(logic [7:0] ch, logic row_end);
    screen_req_t r;
    r = rand_req();
    r.cmd = fbtr_pkg::CMD_TTX;
    r.by[7:0] = ch;
    r.row_end = row_end;
    pend_reqs.push_back(r);
  endtask

  task automatic push_eos();
    screen_req_t r;
    r = rand_req();
    r.cmd = fbtr_pkg::CMD_EOS;
    pend_reqs.push_back(r);
  endtask

  task automatic push_cell(logic [63:0] pat, logic row_end);
    screen_req_t r;
    int l;
    for (l = 0; l < 8; l++) begin
      r = rand_req();
      r.cmd = fbtr_pkg::CMD_LINE;
      r.by = unfold_line(pat[63 - 8*l -: 8]);
      r.row_end = (l == 7) ? row_end : 1'($urandom_range(0, 1));
      pend_reqs.push_back(r);
    end
  endtask

  function automatic logic [63:0] pick_target();
    int s;
    int picks [9] = '{0, 1, 3, 5, 7, 10, 200, 255, 258};
    s = $urandom_range(0, 99);
    if (s < 55) return gen_pat[$urandom_range(0, NGLYPH - 1)];
    if (s < 70) return gen_pat[picks[$urandom_range(0, 8)]];
    if (s < 80) return fbtr_pkg::AMBIG_PATTERN;
    return {$urandom, $urandom};
  endfunction

  task automatic random_items(int n_items);
    screen_req_t r;
    logic [7:0] ch, code;
    int n, sel, s, k;
    n = 0;
    while (n < n_items) begin
      sel = $urandom_range(0, 99);
      if (sel < 50) begin
        push_cell(pick_target(), $urandom_range(0, 3) == 0);
        n += 8;
      end else if (sel < 75) begin
        s = $urandom_range(0, 99);
        ch = (s < 10) ? fbtr_pkg::CHAR_NUL : (s < 25) ? fbtr_pkg::CHAR_SPACE :
             8'($urandom_range(0, 255));
        push_ttx(ch, $urandom_range(0, 4) == 0);
        n++;
      end else if (sel < 82) begin
        s = $urandom_range(0, 99);
        code = (s < 10) ? fbtr_pkg::CHAR_NUL : (s < 20) ? fbtr_pkg::CHAR_SPACE :
               8'($urandom_range(0, 255));
        push_load($urandom_range(0, 9) < 7 ? 9'($urandom_range(0, NGLYPH - 1))
                                           : 9'($urandom_range(NGLYPH, 511)),
                  $urandom_range(0, 1) ? gen_pat[$urandom_range(0, NGLYPH - 1)]
                                       : {$urandom, $urandom},
                  code);
        n++;
      end else if (sel < 87) begin
        push_eos();
        n++;
      end else if (sel < 93) begin
        // broken cell: a few stray lines
        for (k = $urandom_range(1, 7); k > 0; k--) begin
          r = rand_req();
          r.cmd = fbtr_pkg::CMD_LINE;
          pend_reqs.push_back(r);
          n++;
        end
      end else begin
        r = rand_req();
        if (r.cmd == fbtr_pkg::CMD_LOAD && r.idx < NGLYPH) gen_pat[r.idx] = r.pat;
        pend_reqs.push_back(r);
        n++;
      end
    end
  endtask

  task automatic wait_quiet();
    do @(negedge clk); while (pend_reqs.size() != 0 || in_tvalid || text_q.size() != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_cfg(logic [7:0] bg, logic [1:0] fmt, logic alt);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= fbtr_pkg::CFG_BG_MASK;
    cfg_wdata <= bg;
    @(posedge clk);
    cfg_index <= fbtr_pkg::CFG_PIX_FMT;
    cfg_wdata <= {6'd0, fmt};
    @(posedge clk);
    cfg_index <= fbtr_pkg::CFG_ALT_ROM;
    cfg_wdata <= {7'd0, alt};
    @(posedge clk);
    cfg_we <= 1'b0;
    cfg_bg = bg;
    cfg_fmt = fmt;
    cfg_alt = alt;
  endtask

  task automatic run_phase(logic [7:0] bg, logic [1:0] fmt, logic alt, bit quiet,
                           bit burst);
    int k;
    wait_quiet();
    write_cfg(bg, fmt, alt);
    @(negedge clk);
    calm = quiet;
    if (burst) begin
      // drive both pending counts into saturation
      for (k = 0; k < 265; k++)
        push_ttx($urandom_range(0, 1) ? fbtr_pkg::CHAR_NUL : fbtr_pkg::CHAR_SPACE, 1'b0);
      push_ttx(8'h41, 1'b0);
      for (k = 0; k < 265; k++)
        push_ttx($urandom_range(0, 1) ? fbtr_pkg::CHAR_NUL : fbtr_pkg::CHAR_SPACE, 1'b1);
      push_ttx(8'h42, 1'b0);
    end
    random_items(180);
    push_eos();
  endtask

  initial begin : stim
    int i;
    logic [7:0] code;
    logic [63:0] pat;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    write_cfg(8'h00, fbtr_pkg::FMT_1BPP, 1'b0);
    @(negedge clk);

    // full table load
    for (i = 0; i < NGLYPH; i++) begin
      pat = {$urandom, $urandom};
      code = 8'($urandom_range(1, 255));
      case (i)
        0: begin pat = '0; code = fbtr_pkg::CHAR_SPACE; end
        1: begin pat = '1; code = 8'hdb; end
        3: code = fbtr_pkg::CHAR_NUL;
        5: begin pat = fbtr_pkg::AMBIG_PATTERN; code = fbtr_pkg::CHAR_NUL; end
        7: code = fbtr_pkg::CHAR_SPACE;
        200: pat = gen_pat[10];
        255: begin pat = fbtr_pkg::AMBIG_PATTERN; code = 8'h41; end
        default: ;
      endcase
      push_load(9'(i), pat, code);
    end

    // directed
    push_ttx(8'h41, 1'b0);
    push_ttx(fbtr_pkg::CHAR_NUL, 1'b0);
    push_ttx(fbtr_pkg::CHAR_SPACE, 1'b0);
    push_ttx(8'hff, 1'b1);
    push_ttx(fbtr_pkg::CHAR_NUL, 1'b1);
    push_load(9'h1ff, {$urandom, $urandom}, 8'h55);
    push_load(9'(NGLYPH - 1), {$urandom, $urandom}, 8'h7f);
    push_eos();
    push_eos();
    push_cell(fbtr_pkg::AMBIG_PATTERN, 1'b1);
    push_ttx(8'h80, 1'b0);

    random_items(180);
    push_eos();

    run_phase(8'hff, fbtr_pkg::FMT_2BPP, 1'b1, 1'b0, 1'b1);
    run_phase(8'h5a, fbtr_pkg::FMT_4BPP, 1'b0, 1'b1, 1'b0);
    run_phase(8'ha5, fbtr_pkg::FMT_RSVD, 1'b1, 1'b0, 1'b0);
    run_phase(8'h3c, fbtr_pkg::FMT_2BPP, 1'b0, 1'b0, 1'b0);
    run_phase(8'hff, fbtr_pkg::FMT_4BPP, 1'b1, 1'b0, 1'b0);

    wait_quiet();
    $display("requests: %0d (%0d loads, %0d bitmap cells, %0d teletext, %0d end-of-screen)",
             n_reqs, n_loads, n_cells, n_ttx, n_eos);
    $display("text results checked: %0d over 6 register settings, %0d mismatches",
             n_texts, n_bad);
    if (n_bad == 0 && text_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
